FILE: rtl/dcc_pkg.sv
// Shared types, codes and constants of the DMA channel controller.
// Depends on nothing; used by dma_channel_controller.
package dcc_pkg;

  // Channel count range and register map geometry
  localparam int unsigned NUM_CHANNELS_DEF = 8;
  localparam int unsigned MAX_CHANNELS     = 8;
  localparam logic [7:0]  REG_BASE         = 8'h04;
  localparam int unsigned CH_STRIDE        = 28;   // 0x1C bytes per channel

  // Input item kinds
  localparam logic [1:0] IN_REG_WR   = 2'd0;
  localparam logic [1:0] IN_REG_RD   = 2'd1;
  localparam logic [1:0] IN_MEM_DATA = 2'd2;

  // Register offsets inside one channel window
  localparam logic [4:0] REG_SRC  = 5'h00;
  localparam logic [4:0] REG_DST  = 5'h04;
  localparam logic [4:0] REG_XFER = 5'h08;
  localparam logic [4:0] REG_WCNT = 5'h0C;
  localparam logic [4:0] REG_RSVD = 5'h10;
  localparam logic [4:0] REG_FILL = 5'h14;
  localparam logic [4:0] REG_CTRL = 5'h18;

  // Control word fields
  localparam int unsigned CTL_DST_UPD_LO = 10;
  localparam int unsigned CTL_DST_RELOAD = 12;
  localparam int unsigned CTL_SRC_UPD_LO = 13;
  localparam int unsigned CTL_SRC_RELOAD = 15;
  localparam int unsigned CTL_STARTUP_LO = 24;
  localparam int unsigned CTL_IRQ_EN     = 30;
  localparam int unsigned CTL_START      = 31;
  localparam logic [4:0]  STARTUP_MIN    = 5'h10;

  // Address update modes
  localparam logic [1:0] UPD_INC   = 2'd0;
  localparam logic [1:0] UPD_DEC   = 2'd1;
  localparam logic [1:0] UPD_BAD   = 2'd3;

  typedef enum logic [2:0] {
    RES_READ   = 3'd0,
    RES_ACK    = 3'd1,
    RES_MEM_RD = 3'd2,
    RES_MEM_WR = 3'd3,
    RES_DONE   = 3'd4,
    RES_ERROR  = 3'd5
  } res_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_UNKNOWN_REG = 3'd1,
    ERR_BAD_UPDATE  = 3'd2,
    ERR_BAD_STARTUP = 3'd3,
    ERR_UNEXPECTED  = 3'd4
  } err_t;

  // One result beat
  typedef struct packed {
    res_kind_t   kind;
    logic [31:0] addr;
    logic [31:0] data;
    logic [2:0]  ch;
    logic        irq;
    err_t        err;
    logic        last;
  } res_t;

  // Address step for one update mode: +4, -4 or fixed
  function automatic logic [31:0] step_of(input logic [1:0] mode);
    logic [31:0] s;
    case (mode)
      UPD_INC: s = 32'h0000_0004;
      UPD_DEC: s = 32'hFFFF_FFFC;
      default: s = 32'h0000_0000;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/dma_channel_controller.sv
// Multichannel DMA controller: register decode, per-channel registers,
// transfer sequencing and result beat output. Depends on dcc_pkg.
//
// Usage: one command channel in (in_kind, in_offset, in_wdata), taken on a
// rising edge with start high and busy low. Kind 0 writes a register, kind 1
// reads one, kind 2 hands back a memory word that the block asked for.
// Each command gives one or two result beats on the out_ ports, each shown
// for exactly one cycle with out_valid high; out_last marks the final beat.
// Latency: the first beat appears the cycle after the command is taken.
// A new command can be taken while the last beat of the previous one is shown;
// busy is high while a second beat is still queued, which is the only thing
// that holds off the next command.
// A transfer runs one word at a time: a memory read request beat, then for
// each returned word a memory write beat and the next read request, or the
// done beat (irq from the control enable bit) after the last word.
// The receiver cannot stall: every beat is taken in the cycle it is shown.
// Reset (rst_n low, synchronous) clears all channel registers, stops any
// running transfer and drops any queued beat.
module dma_channel_controller #(
  parameter int unsigned NUM_CHANNELS = dcc_pkg::NUM_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_offset,
  input  logic [31:0] in_wdata,
  output logic        out_valid,
  output logic [2:0]  out_kind_res,
  output logic [31:0] out_mem_addr,
  output logic [31:0] out_rdata,
  output logic [2:0]  out_channel_id,
  output logic        out_irq,
  output logic [2:0]  out_error_code,
  output logic        out_last
);

  localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Per-channel registers
  logic [31:0] src_reg_r  [NUM_CHANNELS];
  logic [31:0] dst_reg_r  [NUM_CHANNELS];
  logic [31:0] wcnt_reg_r [NUM_CHANNELS];
  logic [31:0] ctl_reg_r  [NUM_CHANNELS];

  // Active transfer state
  logic             run_busy_r, run_busy_nxt;
  logic [IDX_W-1:0] active_r, active_nxt;
  logic [31:0]      words_done_r, words_done_nxt;
  logic [31:0]      cur_src_r, cur_src_nxt;
  logic [31:0]      cur_dst_r, cur_dst_nxt;
  logic [31:0]      act_ctl_r, act_ctl_nxt;
  logic [31:0]      act_wcnt_r, act_wcnt_nxt;

  // Output beat and queued second beat
  logic             out_valid_r;
  dcc_pkg::res_t    out_r;
  logic             pend_valid_r;
  dcc_pkg::res_t    pend_r;

  // Decode and per-command results
  logic             accept;
  logic [7:0]       rel_off;
  logic [3:0]       dec_ch;
  logic [7:0]       dec_base;
  logic [4:0]       reg_sel;
  logic             have_ch;
  logic [IDX_W-1:0] cidx;
  logic             locked;
  logic             ctl_old_start;
  logic [31:0]      wd_inc;
  logic             last_word;
  dcc_pkg::res_t    r0, r1;
  logic             two_res;
  logic             src_we, dst_we, wcnt_we, ctl_we;
  logic [IDX_W-1:0] ctl_widx;
  logic [31:0]      ctl_wdata;

  assign accept = start && !busy;

  // Offset decode: channel = (offset-4)/0x1C, register = remainder
  always_comb begin
    rel_off  = in_offset - dcc_pkg::REG_BASE;
    dec_ch   = 4'd0;
    dec_base = 8'd0;
    for (int k = 1; k <= dcc_pkg::MAX_CHANNELS; k++) begin
      if (rel_off >= 8'(k * dcc_pkg::CH_STRIDE)) begin
        dec_ch   = 4'(k);
        dec_base = 8'(k * dcc_pkg::CH_STRIDE);
      end
    end
    reg_sel = 5'(rel_off - dec_base);
    have_ch = (in_offset >= dcc_pkg::REG_BASE) && (dec_ch < 4'(NUM_CHANNELS));
    cidx    = dec_ch[IDX_W-1:0];
  end

  assign locked        = run_busy_r && (cidx == active_r);
  assign ctl_old_start = ctl_reg_r[cidx][dcc_pkg::CTL_START];
  assign wd_inc        = words_done_r + 32'd1;
  assign last_word     = (wd_inc >= act_wcnt_r) || (wd_inc == 32'd0);

  // Command handling: results and next state
  always_comb begin
    r0             = '0;
    r1             = '0;
    r1.last        = 1'b1;
    two_res        = 1'b0;
    src_we         = 1'b0;
    dst_we         = 1'b0;
    wcnt_we        = 1'b0;
    ctl_we         = 1'b0;
    ctl_widx       = cidx;
    ctl_wdata      = in_wdata;
    run_busy_nxt   = run_busy_r;
    active_nxt     = active_r;
    words_done_nxt = words_done_r;
    cur_src_nxt    = cur_src_r;
    cur_dst_nxt    = cur_dst_r;
    act_ctl_nxt    = act_ctl_r;
    act_wcnt_nxt   = act_wcnt_r;

    if ((in_kind == dcc_pkg::IN_REG_WR) || (in_kind == dcc_pkg::IN_REG_RD)) begin
      r0.ch = have_ch ? 3'(dec_ch) : 3'd0;
      if (!have_ch) begin
        r0.kind = (in_kind == dcc_pkg::IN_REG_WR) ? dcc_pkg::RES_ACK : dcc_pkg::RES_READ;
      end else if (in_kind == dcc_pkg::IN_REG_RD) begin
        if (reg_sel == dcc_pkg::REG_SRC) begin
          r0.kind = dcc_pkg::RES_READ;
          r0.data = src_reg_r[cidx];
        end else if (reg_sel == dcc_pkg::REG_CTRL) begin
          r0.kind = dcc_pkg::RES_READ;
          r0.data = ctl_reg_r[cidx];
        end else begin
          r0.kind = dcc_pkg::RES_ERROR;
          r0.err  = dcc_pkg::ERR_UNKNOWN_REG;
        end
      end else begin
        r0.kind = dcc_pkg::RES_ACK;
        unique case (reg_sel) inside
          dcc_pkg::REG_SRC:  src_we = 1'b1;
          dcc_pkg::REG_DST:  dst_we = 1'b1;
          dcc_pkg::REG_WCNT: wcnt_we = !locked;
          dcc_pkg::REG_XFER, dcc_pkg::REG_RSVD, dcc_pkg::REG_FILL: ;
          dcc_pkg::REG_CTRL: begin
            if (!locked) begin
              ctl_we = 1'b1;
              if (ctl_old_start || !in_wdata[dcc_pkg::CTL_START]) begin
                // plain store
              end else if (run_busy_r) begin
                ctl_wdata[dcc_pkg::CTL_START] = 1'b0;
                r0.kind = dcc_pkg::RES_ERROR;
                r0.err  = dcc_pkg::ERR_UNEXPECTED;
              end else if (in_wdata[dcc_pkg::CTL_STARTUP_LO +: 5] < dcc_pkg::STARTUP_MIN)
              begin
                ctl_wdata[dcc_pkg::CTL_START] = 1'b0;
                r0.kind = dcc_pkg::RES_ERROR;
                r0.err  = dcc_pkg::ERR_BAD_STARTUP;
              end else if ((in_wdata[dcc_pkg::CTL_DST_UPD_LO +: 2] == dcc_pkg::UPD_BAD) ||
                           (in_wdata[dcc_pkg::CTL_SRC_UPD_LO +: 2] == dcc_pkg::UPD_BAD))
              begin
                ctl_wdata[dcc_pkg::CTL_START] = 1'b0;
                r0.kind = dcc_pkg::RES_ERROR;
                r0.err  = dcc_pkg::ERR_BAD_UPDATE;
              end else begin
                // Start a transfer
                two_res        = 1'b1;
                active_nxt     = cidx;
                words_done_nxt = 32'd0;
                cur_src_nxt    = src_reg_r[cidx];
                cur_dst_nxt    = dst_reg_r[cidx];
                act_ctl_nxt    = in_wdata;
                act_wcnt_nxt   = wcnt_reg_r[cidx];
                r1.ch          = 3'(dec_ch);
                if (wcnt_reg_r[cidx] == 32'd0) begin
                  ctl_wdata[dcc_pkg::CTL_START] = 1'b0;
                  run_busy_nxt = 1'b0;
                  r1.kind      = dcc_pkg::RES_DONE;
                  r1.irq       = in_wdata[dcc_pkg::CTL_IRQ_EN];
                end else begin
                  run_busy_nxt = 1'b1;
                  r1.kind      = dcc_pkg::RES_MEM_RD;
                  r1.addr      = src_reg_r[cidx];
                end
              end
            end
          end
          default: begin
            r0.kind = dcc_pkg::RES_ERROR;
            r0.err  = dcc_pkg::ERR_UNKNOWN_REG;
          end
        endcase
      end
    end else if ((in_kind == dcc_pkg::IN_MEM_DATA) && run_busy_r) begin
      // Returned word: write it, then next read or done
      two_res        = 1'b1;
      r0.kind        = dcc_pkg::RES_MEM_WR;
      r0.addr        = cur_dst_r;
      r0.data        = in_wdata;
      r0.ch          = 3'(active_r);
      r1.ch          = 3'(active_r);
      words_done_nxt = wd_inc;
      cur_dst_nxt    = cur_dst_r + dcc_pkg::step_of(act_ctl_r[dcc_pkg::CTL_DST_UPD_LO +: 2]);
      cur_src_nxt    = cur_src_r + dcc_pkg::step_of(act_ctl_r[dcc_pkg::CTL_SRC_UPD_LO +: 2]);
      if (last_word) begin
        run_busy_nxt = 1'b0;
        ctl_we       = 1'b1;
        ctl_widx     = active_r;
        ctl_wdata    = act_ctl_r;
        ctl_wdata[dcc_pkg::CTL_START] = 1'b0;
        r1.kind      = dcc_pkg::RES_DONE;
        r1.irq       = act_ctl_r[dcc_pkg::CTL_IRQ_EN];
      end else begin
        r1.kind      = dcc_pkg::RES_MEM_RD;
        r1.addr      = cur_src_nxt;
      end
    end else begin
      r0.kind = dcc_pkg::RES_ERROR;
      r0.err  = dcc_pkg::ERR_UNEXPECTED;
    end
    r0.last = !two_res;
  end

  // Channel register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        src_reg_r[i]  <= '0;
        dst_reg_r[i]  <= '0;
        wcnt_reg_r[i] <= '0;
        ctl_reg_r[i]  <= '0;
      end
    end else if (accept) begin
      if (src_we)  src_reg_r[cidx]     <= in_wdata;
      if (dst_we)  dst_reg_r[cidx]     <= in_wdata;
      if (wcnt_we) wcnt_reg_r[cidx]    <= in_wdata;
      if (ctl_we)  ctl_reg_r[ctl_widx] <= ctl_wdata;
    end
  end

  // Transfer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_busy_r   <= 1'b0;
      active_r     <= '0;
      words_done_r <= '0;
      cur_src_r    <= '0;
      cur_dst_r    <= '0;
      act_ctl_r    <= '0;
      act_wcnt_r   <= '0;
    end else if (accept) begin
      run_busy_r   <= run_busy_nxt;
      active_r     <= active_nxt;
      words_done_r <= words_done_nxt;
      cur_src_r    <= cur_src_nxt;
      cur_dst_r    <= cur_dst_nxt;
      act_ctl_r    <= act_ctl_nxt;
      act_wcnt_r   <= act_wcnt_nxt;
    end
  end

  // Result beats: first beat out, second beat queued behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r  <= 1'b1;
      out_r        <= r0;
      pend_valid_r <= two_res;
      pend_r       <= r1;
    end else if (pend_valid_r) begin
      out_valid_r  <= 1'b1;
      out_r        <= pend_r;
      pend_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= 1'b0;
    end
  end

  assign busy           = pend_valid_r;
  assign out_valid      = out_valid_r;
  assign out_kind_res   = out_r.kind;
  assign out_mem_addr   = out_r.addr;
  assign out_rdata      = out_r.data;
  assign out_channel_id = out_r.ch;
  assign out_irq        = out_r.irq;
  assign out_error_code = out_r.err;
  assign out_last       = out_r.last;

`ifndef NO_ASSERTIONS
  // A queued second beat always sits behind a shown first beat
  a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> out_valid_r)
    else $error("queued beat without a beat on the output");

  // A beat that is not the last is followed at once by another
  a_last_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.last) |=> out_valid_r)
    else $error("beat sequence broken before last beat");

  // A read request is only issued for a running transfer
  a_rd_running: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.kind == dcc_pkg::RES_MEM_RD)) |-> run_busy_r)
    else $error("memory read request without a running transfer");

  // Done is shown only after the transfer has stopped
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.kind == dcc_pkg::RES_DONE)) |-> !run_busy_r)
    else $error("done reported while transfer still running");

  // Error code present exactly on error beats
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_r.kind == dcc_pkg::RES_ERROR) == (out_r.err != dcc_pkg::ERR_NONE)))
    else $error("error code does not match result kind");
`endif

endmodule
